@@ design/s4b_pkg.sv @@
package s4b_pkg;

    // default frame geometry
    localparam int PAYLOAD_BYTES_DEF = 64;
    localparam int ENCODED_BYTES_DEF = 85;

    // reset values of the sync registers
    localparam logic [7:0] SYNC_FIRST_RST  = 8'hAA;
    localparam logic [7:0] SYNC_SECOND_RST = 8'hD4;

    // crc-16/ccitt-false
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    // configuration register indexes
    localparam logic REG_SYNC_FIRST  = 1'b0;
    localparam logic REG_SYNC_SECOND = 1'b1;

    // symbol decode result: bad flag over nibble
    localparam logic [4:0] SYM_BAD = 5'h10;

    // front end to decoder control
    typedef struct packed {
        logic go;   // new 40-bit group ready
        logic clr;  // frame start, reload running state
    } t_dec_ctl;

    // decoder status seen by front end and drain
    typedef struct packed {
        logic       busy;
        logic       ok;
        logic [7:0] len;
    } t_dec_stat;

    // reverse 5b-to-4b symbol table
    function automatic logic [4:0] sym_decode(input logic [4:0] sym);
        logic [4:0] res;
        case (sym)
            5'd9:    res = 5'h01;
            5'd10:   res = 5'h04;
            5'd11:   res = 5'h05;
            5'd14:   res = 5'h08;
            5'd15:   res = 5'h09;
            5'd18:   res = 5'h06;
            5'd19:   res = 5'h07;
            5'd20:   res = 5'h02;
            5'd21:   res = 5'h03;
            5'd22:   res = 5'h0A;
            5'd23:   res = 5'h0B;
            5'd26:   res = 5'h0E;
            5'd27:   res = 5'h0F;
            5'd28:   res = 5'h0C;
            5'd29:   res = 5'h0D;
            5'd30:   res = 5'h00;
            default: res = SYM_BAD;
        endcase
        return res;
    endfunction

    // one byte through the crc, msb first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

@@ design/s4b_front.sv @@
module s4b_front #(
    parameter int ENCODED_BYTES = s4b_pkg::ENCODED_BYTES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wen,
    input  logic               i_cfg_addr,
    input  logic [7:0]         i_cfg_wdata,
    input  logic               i_rx_valid,
    output logic               o_rx_ready,
    input  logic [7:0]         i_rx_byte,
    input  s4b_pkg::t_dec_stat i_stat,
    input  logic               i_drain_busy,
    output s4b_pkg::t_dec_ctl  o_ctl,
    output logic [39:0]        o_grp,
    output logic               o_start
);

    localparam int FW = $clog2(ENCODED_BYTES + 1);

    typedef enum logic [2:0] {
        ST_SYNC1,
        ST_SYNC2,
        ST_BODY,
        ST_WAIT,
        ST_DRAIN
    } t_state;

    t_state            r_state;
    logic [7:0]        r_sync_first;
    logic [7:0]        r_sync_second;
    logic [FW-1:0]     r_fcnt;
    logic [2:0]        r_gcnt;
    logic [39:0]       r_shift;
    s4b_pkg::t_dec_ctl r_ctl;
    logic              acc;
    logic [FW-1:0]     n_fcnt;

    assign o_rx_ready = (r_state == ST_SYNC1) || (r_state == ST_SYNC2) || (r_state == ST_BODY);
    assign acc        = i_rx_valid && o_rx_ready;
    assign n_fcnt     = r_fcnt + FW'(1);

    // drain may start once the last group has been through the decoder
    assign o_start = (r_state == ST_WAIT) && !r_ctl.go && !i_stat.busy;
    assign o_ctl   = r_ctl;
    assign o_grp   = r_shift;

    // sync registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_first  <= s4b_pkg::SYNC_FIRST_RST;
            r_sync_second <= s4b_pkg::SYNC_SECOND_RST;
        end else if (i_cfg_wen) begin
            case (i_cfg_addr)
                s4b_pkg::REG_SYNC_FIRST:  r_sync_first  <= i_cfg_wdata;
                s4b_pkg::REG_SYNC_SECOND: r_sync_second <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // decoder strobes: group ready on every fifth body byte, clear on frame start
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl.go  <= acc && (r_state == ST_BODY) && (r_gcnt == 3'd4);
            r_ctl.clr <= acc && (r_state == ST_SYNC2) && (i_rx_byte == r_sync_second);
        end
    end

    // sync hunt, byte collection and frame sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_SYNC1;
            r_fcnt  <= '0;
            r_gcnt  <= '0;
            r_shift <= '0;
        end else begin
            case (r_state)
                ST_SYNC1: begin
                    if (acc) begin
                        r_state <= (i_rx_byte == r_sync_first) ? ST_SYNC2 : ST_SYNC1;
                    end
                end
                ST_SYNC2: begin
                    if (acc) begin
                        if (i_rx_byte == r_sync_second) begin
                            r_state <= ST_BODY;
                            r_fcnt  <= '0;
                            r_gcnt  <= '0;
                            r_shift <= '0;
                        end else begin
                            r_state <= (i_rx_byte == r_sync_first) ? ST_SYNC2 : ST_SYNC1;
                        end
                    end
                end
                ST_BODY: begin
                    if (acc) begin
                        r_shift <= {r_shift[31:0], i_rx_byte};
                        r_fcnt  <= n_fcnt;
                        if (r_gcnt == 3'd4) begin
                            r_gcnt <= '0;
                        end else begin
                            r_gcnt <= r_gcnt + 3'd1;
                        end
                        if (n_fcnt == FW'(ENCODED_BYTES)) begin
                            r_state <= ST_WAIT;
                        end
                    end
                end
                ST_WAIT: begin
                    if (o_start) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (!i_drain_busy) begin
                        r_state <= ST_SYNC1;
                    end
                end
                default: r_state <= ST_SYNC1;
            endcase
        end
    end

endmodule

@@ design/s4b_decode.sv @@
module s4b_decode #(
    parameter int PAYLOAD_BYTES = s4b_pkg::PAYLOAD_BYTES_DEF,
    parameter int ENCODED_BYTES = s4b_pkg::ENCODED_BYTES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  s4b_pkg::t_dec_ctl             i_ctl,
    input  logic [39:0]                   i_grp,
    output s4b_pkg::t_dec_stat            o_stat,
    output logic                          o_wr_en,
    output logic [$clog2(PAYLOAD_BYTES)-1:0] o_wr_addr,
    output logic [7:0]                    o_wr_data
);

    localparam int AW       = $clog2(PAYLOAD_BYTES);
    localparam int DEC_MAX  = (ENCODED_BYTES / 5) * 4;
    localparam int DEC_TOP  = (DEC_MAX > PAYLOAD_BYTES + 3) ? DEC_MAX : PAYLOAD_BYTES + 3;
    localparam int DW       = $clog2(DEC_TOP + 1);
    localparam int CHECK_HI = PAYLOAD_BYTES + 2;
    localparam int CHECK_LO = PAYLOAD_BYTES + 3;

    logic [39:0]   r_grp;
    logic [1:0]    r_step;
    logic          r_busy;
    logic          r_err;
    logic [15:0]   r_crc;
    logic [15:0]   r_check;
    logic [7:0]    r_len;
    logic [DW-1:0] r_dcnt;

    logic [4:0]    hi_sym;
    logic [4:0]    lo_sym;
    logic          bad;
    logic [7:0]    dbyte;
    logic [DW-1:0] waddr_full;
    logic          in_crc;

    // one symbol pair per cycle from the top of the group
    assign hi_sym     = s4b_pkg::sym_decode(r_grp[39:35]);
    assign lo_sym     = s4b_pkg::sym_decode(r_grp[34:30]);
    assign bad        = hi_sym[4] || lo_sym[4];
    assign dbyte      = {hi_sym[3:0], lo_sym[3:0]};
    assign in_crc     = r_dcnt < DW'(CHECK_HI);
    assign waddr_full = r_dcnt - DW'(2);

    // payload store write
    assign o_wr_en   = r_busy && !bad && in_crc && (r_dcnt >= DW'(2));
    assign o_wr_addr = waddr_full[AW-1:0];
    assign o_wr_data = dbyte;

    assign o_stat.busy = r_busy;
    assign o_stat.ok   = !r_err && (r_crc == r_check);
    assign o_stat.len  = r_len;

    // group sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_ctl.go && !r_err) begin
            r_busy <= 1'b1;
            r_step <= '0;
        end else if (r_busy) begin
            r_step <= r_step + 2'd1;
            if (bad || r_step == 2'd3) begin
                r_busy <= 1'b0;
            end
        end
    end

    // group data
    always_ff @(posedge i_clk) begin
        if (i_ctl.go) begin
            r_grp <= i_grp;
        end else if (r_busy) begin
            r_grp <= {r_grp[29:0], 10'd0};
        end
    end

    // running frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err   <= 1'b0;
            r_crc   <= s4b_pkg::CRC_INIT;
            r_check <= '0;
            r_len   <= '0;
            r_dcnt  <= '0;
        end else if (i_ctl.clr) begin
            r_err   <= 1'b0;
            r_crc   <= s4b_pkg::CRC_INIT;
            r_check <= '0;
            r_len   <= '0;
            r_dcnt  <= '0;
        end else if (r_busy) begin
            if (bad) begin
                r_err <= 1'b1;
            end else begin
                if (in_crc) begin
                    r_crc <= s4b_pkg::crc_byte(r_crc, dbyte);
                end
                if (r_dcnt == '0) begin
                    r_len <= dbyte;
                end
                if (r_dcnt == DW'(CHECK_HI)) begin
                    r_check[15:8] <= dbyte;
                end
                if (r_dcnt == DW'(CHECK_LO)) begin
                    r_check[7:0] <= dbyte;
                end
                r_dcnt <= r_dcnt + DW'(1);
            end
        end
    end

    // a group never lands on one still being decoded
    a_go_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.go |-> !r_busy)
        else $error("group issued while decoder busy");

    // frame start never cuts into a group
    a_clr_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.clr |-> !r_busy && !i_ctl.go)
        else $error("frame start while decoder busy");

endmodule

@@ design/s4b_drain.sv @@
module s4b_drain #(
    parameter int PAYLOAD_BYTES = s4b_pkg::PAYLOAD_BYTES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_wr_en,
    input  logic [$clog2(PAYLOAD_BYTES)-1:0] i_wr_addr,
    input  logic [7:0]                       i_wr_data,
    input  logic                             i_start,
    input  s4b_pkg::t_dec_stat               i_stat,
    output logic                             o_active,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [7:0]                       o_out_byte,
    output logic                             o_out_last,
    output logic                             o_out_is_pad
);

    localparam int AW = $clog2(PAYLOAD_BYTES);
    localparam int CW = $clog2(PAYLOAD_BYTES + 1);

    logic [7:0]    mem [PAYLOAD_BYTES];
    logic [7:0]    r_rdata;
    logic          r_active;
    logic          r_pad;
    logic [CW-1:0] r_idx;
    logic [CW-1:0] r_cnt;
    logic          r_ovalid;
    logic [7:0]    r_obyte;
    logic          r_olast;
    logic          r_opad;

    logic [CW-1:0] n_idx;
    logic [CW-1:0] idx_inc;
    logic [CW-1:0] len_sat;
    logic          load;

    assign len_sat = (i_stat.len > 8'(PAYLOAD_BYTES)) ? CW'(PAYLOAD_BYTES)
                                                     : CW'(i_stat.len);
    assign idx_inc = r_idx + CW'(1);
    assign load    = r_active && (r_idx != r_cnt) && (!r_ovalid || i_out_ready);
    assign n_idx   = i_start ? '0 : (load ? idx_inc : r_idx);

    assign o_active     = r_active;
    assign o_out_valid  = r_ovalid;
    assign o_out_byte   = r_obyte;
    assign o_out_last   = r_olast;
    assign o_out_is_pad = r_opad;

    // payload store, read address runs one ahead so data is ready at load
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        r_rdata <= mem[n_idx[AW-1:0]];
    end

    // readout sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_idx    <= '0;
            r_cnt    <= '0;
            r_pad    <= 1'b0;
        end else if (i_start) begin
            r_active <= 1'b1;
            r_idx    <= '0;
            r_cnt    <= i_stat.ok ? len_sat : CW'(PAYLOAD_BYTES);
            r_pad    <= !i_stat.ok;
        end else if (r_active) begin
            r_idx <= n_idx;
            if (r_idx == r_cnt) begin
                r_active <= 1'b0;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (load) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_obyte <= r_pad ? 8'd0 : r_rdata;
            r_olast <= (idx_inc == r_cnt);
            r_opad  <= r_pad;
        end
    end

    // a new readout never starts over a running one
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_active)
        else $error("readout started while active");

    // index never runs past the item count
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> r_idx <= r_cnt)
        else $error("readout index past count");

    // the store is not written while it is being read out
    a_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> !i_wr_en)
        else $error("store written during readout");

endmodule

@@ design/sync_4b5b_crc_packet_receiver_top.sv @@
// 4b5b frame receiver with crc-16/ccitt-false check. Line bytes come in on
// the rx channel; the block hunts for the two sync bytes (registers 0 and 1),
// then takes ENCODED_BYTES body bytes at one request per cycle. Every fifth
// body byte hands a 40-bit group to the decoder, which turns one symbol pair
// into a frame byte per cycle and folds it into the crc. After the last body
// byte rx ready stays low while the last group finishes, then while the
// payload store is read out: one result a cycle when the output side takes
// them, min(length, PAYLOAD_BYTES) payload bytes on a good frame or
// PAYLOAD_BYTES zero bytes with out_is_pad on a symbol or crc error. Ready
// returns once the readout has gone idle and the front end has left its
// drain state.
module sync_4b5b_crc_packet_receiver_top #(
    parameter int PAYLOAD_BYTES = s4b_pkg::PAYLOAD_BYTES_DEF,
    parameter int ENCODED_BYTES = s4b_pkg::ENCODED_BYTES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wen,
    input  logic       i_cfg_addr,
    input  logic [7:0] i_cfg_wdata,
    input  logic       i_rx_valid,
    output logic       o_rx_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_out_last,
    output logic       o_out_is_pad
);

    localparam int AW = $clog2(PAYLOAD_BYTES);

    s4b_pkg::t_dec_ctl  dec_ctl;
    s4b_pkg::t_dec_stat dec_stat;
    logic [39:0]        grp;
    logic               drain_start;
    logic               drain_busy;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [7:0]         wr_data;

    // sync hunt and byte collection
    s4b_front #(
        .ENCODED_BYTES (ENCODED_BYTES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wen    (i_cfg_wen),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_rx_valid   (i_rx_valid),
        .o_rx_ready   (o_rx_ready),
        .i_rx_byte    (i_rx_byte),
        .i_stat       (dec_stat),
        .i_drain_busy (drain_busy),
        .o_ctl        (dec_ctl),
        .o_grp        (grp),
        .o_start      (drain_start)
    );

    // symbol decode and crc
    s4b_decode #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES),
        .ENCODED_BYTES (ENCODED_BYTES)
    ) u_decode (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (dec_ctl),
        .i_grp     (grp),
        .o_stat    (dec_stat),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data)
    );

    // payload store and result output
    s4b_drain #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_drain (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_wr_en      (wr_en),
        .i_wr_addr    (wr_addr),
        .i_wr_data    (wr_data),
        .i_start      (drain_start),
        .i_stat       (dec_stat),
        .o_active     (drain_busy),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_byte   (o_out_byte),
        .o_out_last   (o_out_last),
        .o_out_is_pad (o_out_is_pad)
    );

endmodule
